// File: src/pcbs_pkg.sv
// Package for the capture buffer scheduler: sizes, codes, word types and helpers.
package pcbs_pkg;

  // Ring geometry
  localparam int unsigned RING_SLOTS = 2;
  localparam int unsigned IDX_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned PEND_W     = $clog2(RING_SLOTS + 1);

  // Field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned HND_W  = 32;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_ERROR    = 2'd2,
    CMD_ABORT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_STREAMING = 2'd1,
    MODE_STOPPED   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_SCHEDULED = 2'd1,
    SLOT_ARMED     = 2'd2
  } slot_state_e;

  // Input word
  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] buffer_address;
    logic [CNT_W-1:0]  sample_count;
    logic [HND_W-1:0]  handler_id;
    logic              overflow_seen;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              rx_complete;
    logic              stream_stopped;
    logic              dma_error;
    logic              overrun;
    logic              arm_valid;
    logic [ADDR_W-1:0] arm_address;
    logic [CNT_W-1:0]  arm_count;
    logic [HND_W-1:0]  arm_handler;
    logic              done_slot;
    logic [ADDR_W-1:0] done_address;
    logic [CNT_W-1:0]  done_count;
    logic              active;
  } out_word_t;

  // One ring descriptor
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [HND_W-1:0]  handler;
  } desc_t;

  // Control from the sequencer to the descriptor store
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

  // Ring index increment with wrap
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(RING_SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

// File: src/pcbs_desc_store.sv
// Descriptor store: one register set per ring slot, one write and one read port.
module pcbs_desc_store (
  input  logic                clk_i,
  input  pcbs_pkg::store_req_t req_i,
  input  pcbs_pkg::desc_t     wdata_i,
  output pcbs_pkg::desc_t     rdata_o
);

  pcbs_pkg::desc_t slot_q [pcbs_pkg::RING_SLOTS];

  // Write the fill slot on schedule
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      slot_q[req_i.wr_idx] <= wdata_i;
    end
  end

  // Single read port for the slot being armed
  assign rdata_o = slot_q[req_i.rd_idx];

endmodule

// File: src/pcbs_ctrl.sv
// Scheduler sequencer: run mode, ring pointers, slot status and result decode.
module pcbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  pcbs_pkg::in_word_t   word_i,
  input  pcbs_pkg::desc_t      rdata_i,
  output pcbs_pkg::store_req_t req_o,
  output pcbs_pkg::desc_t      wdata_o,
  output pcbs_pkg::out_word_t  result_o
);

  pcbs_pkg::mode_e                   mode_q, mode_d;
  logic [pcbs_pkg::IDX_W-1:0]        fill_q, fill_d;
  logic [pcbs_pkg::IDX_W-1:0]        drain_q, drain_d;
  logic [pcbs_pkg::PEND_W-1:0]       pend_q, pend_d;
  pcbs_pkg::slot_state_e             status_q [pcbs_pkg::RING_SLOTS];
  pcbs_pkg::slot_state_e             status_d [pcbs_pkg::RING_SLOTS];
  pcbs_pkg::desc_t                   armed_q, armed_d;
  pcbs_pkg::desc_t                   arm_desc;
  logic [pcbs_pkg::IDX_W-1:0]        drain_nxt;
  pcbs_pkg::cmd_e                    cmd;

  assign cmd       = pcbs_pkg::cmd_e'(word_i.command);
  assign drain_nxt = pcbs_pkg::next_idx(drain_q);

  assign wdata_o.addr    = word_i.buffer_address;
  assign wdata_o.count   = word_i.sample_count;
  assign wdata_o.handler = word_i.handler_id;

  // Forward the word being written when the arm reads the same slot
  assign arm_desc = (req_o.wr_en && (req_o.rd_idx == req_o.wr_idx)) ? wdata_o : rdata_i;

  // Next state and result for one command word
  always_comb begin
    mode_d   = mode_q;
    fill_d   = fill_q;
    drain_d  = drain_q;
    pend_d   = pend_q;
    armed_d  = armed_q;
    status_d = status_q;
    req_o    = '0;
    result_o = '0;

    unique case (cmd)
      pcbs_pkg::CMD_SCHEDULE: begin
        if (status_q[fill_q] == pcbs_pkg::SLOT_FREE) begin
          req_o.wr_en       = 1'b1;
          req_o.wr_idx      = fill_q;
          status_d[fill_q]  = pcbs_pkg::SLOT_SCHEDULED;
          fill_d            = pcbs_pkg::next_idx(fill_q);
          pend_d            = pend_q + pcbs_pkg::PEND_W'(1);
          req_o.rd_idx      = drain_q;
          if ((mode_q == pcbs_pkg::MODE_IDLE || mode_q == pcbs_pkg::MODE_STOPPED) &&
              status_d[drain_q] == pcbs_pkg::SLOT_SCHEDULED) begin
            // arm the oldest waiting slot
            pend_d               = pend_q;
            status_d[drain_q]    = pcbs_pkg::SLOT_ARMED;
            mode_d               = pcbs_pkg::MODE_STREAMING;
            armed_d              = arm_desc;
            result_o.arm_valid   = 1'b1;
            result_o.arm_address = arm_desc.addr;
            result_o.arm_count   = arm_desc.count;
            result_o.arm_handler = arm_desc.handler;
          end
        end
      end
      pcbs_pkg::CMD_COMPLETE: begin
        if (status_q[drain_q] == pcbs_pkg::SLOT_ARMED) begin
          result_o.rx_complete  = 1'b1;
          result_o.done_slot    = drain_q[0];
          result_o.done_address = armed_q.addr;
          result_o.done_count   = armed_q.count;
          status_d[drain_q]     = pcbs_pkg::SLOT_FREE;
          drain_d               = drain_nxt;
          req_o.rd_idx          = drain_nxt;
          if (pend_q != '0) begin
            if (status_q[drain_nxt] == pcbs_pkg::SLOT_SCHEDULED) begin
              pend_d               = pend_q - pcbs_pkg::PEND_W'(1);
              status_d[drain_nxt]  = pcbs_pkg::SLOT_ARMED;
              mode_d               = pcbs_pkg::MODE_STREAMING;
              armed_d              = arm_desc;
              result_o.arm_valid   = 1'b1;
              result_o.arm_address = arm_desc.addr;
              result_o.arm_count   = arm_desc.count;
              result_o.arm_handler = arm_desc.handler;
            end
          end else begin
            mode_d                  = pcbs_pkg::MODE_STOPPED;
            result_o.stream_stopped = 1'b1;
          end
        end
        result_o.overrun = word_i.overflow_seen;
      end
      pcbs_pkg::CMD_ERROR: begin
        // the armed slot goes back in line as the oldest one
        if (status_q[drain_q] == pcbs_pkg::SLOT_ARMED) begin
          status_d[drain_q] = pcbs_pkg::SLOT_SCHEDULED;
          pend_d            = pend_q + pcbs_pkg::PEND_W'(1);
        end
        mode_d             = pcbs_pkg::MODE_STOPPED;
        result_o.dma_error = 1'b1;
        result_o.overrun   = word_i.overflow_seen;
      end
      pcbs_pkg::CMD_ABORT: begin
        if (mode_q != pcbs_pkg::MODE_IDLE) begin
          mode_d  = pcbs_pkg::MODE_IDLE;
          fill_d  = '0;
          drain_d = '0;
          pend_d  = '0;
          for (int i = 0; i < int'(pcbs_pkg::RING_SLOTS); i++) begin
            status_d[i] = pcbs_pkg::SLOT_FREE;
          end
        end
      end
      default: begin
      end
    endcase

    result_o.active = (mode_d != pcbs_pkg::MODE_IDLE);
    if (!valid_i) begin
      req_o.wr_en = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pcbs_pkg::MODE_IDLE;
      fill_q  <= '0;
      drain_q <= '0;
      pend_q  <= '0;
      for (int i = 0; i < int'(pcbs_pkg::RING_SLOTS); i++) begin
        status_q[i] <= pcbs_pkg::SLOT_FREE;
      end
    end else if (valid_i) begin
      mode_q   <= mode_d;
      fill_q   <= fill_d;
      drain_q  <= drain_d;
      pend_q   <= pend_d;
      status_q <= status_d;
    end
  end

  // Copy of the armed descriptor, reported on completion
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      armed_q <= armed_d;
    end
  end

endmodule

// File: src/ping_pong_capture_buffer_scheduler.sv
// Top level: command word register, sequencer, descriptor store, result register.
// Path: a taken word passes the input register, the sequencer and the result register;
//   its result on result_o is marked by result_valid_o.
// Throughput: one command word per cycle; busy stays low, the input and result
//   registers overlap successive words, and the receiver cannot stall.
// Reset (rst_ni low, asynchronous): idle mode, pointers cleared, all slots free, no result.
module ping_pong_capture_buffer_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pcbs_pkg::in_word_t  cmd_i,
  output logic                result_valid_o,
  output pcbs_pkg::out_word_t result_o
);

  logic                 in_valid_q;
  pcbs_pkg::in_word_t   in_q;
  logic                 res_valid_q;
  pcbs_pkg::out_word_t  res_q;
  pcbs_pkg::out_word_t  res_d;
  pcbs_pkg::store_req_t store_req;
  pcbs_pkg::desc_t      store_wdata;
  pcbs_pkg::desc_t      store_rdata;

  // Every word finishes in one pass, so the block never refuses one
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= cmd_i;
    end
  end

  pcbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .word_i   (in_q),
    .rdata_i  (store_rdata),
    .req_o    (store_req),
    .wdata_o  (store_wdata),
    .result_o (res_d)
  );

  pcbs_desc_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// File: src/pcbs_checker.sv
// Port-level checker for the capture buffer scheduler, bound to the top level.
module pcbs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input pcbs_pkg::out_word_t result_o
);

  // A result word follows an accepted command word through the input and result registers
  a_result_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result word without an accepted command word");

  // Completion fields are zero unless a buffer completed
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.rx_complete) |->
      (result_o.done_address == '0 && result_o.done_count == '0 &&
       result_o.done_slot == 1'b0 && !result_o.stream_stopped))
    else $error("completion fields set without a completion");

  // Arm fields are zero unless a descriptor was armed
  a_arm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.arm_valid) |->
      (result_o.arm_address == '0 && result_o.arm_count == '0 &&
       result_o.arm_handler == '0))
    else $error("arm fields set without an armed descriptor");

  // An error stops the block: no arm, no completion, still active
  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.dma_error) |->
      (!result_o.arm_valid && !result_o.rx_complete && result_o.active))
    else $error("error word with arm or completion, or block idle");

  // Arming or a stream stop always leaves the block active
  a_arm_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.arm_valid || result_o.stream_stopped)) |->
      result_o.active)
    else $error("arm or stream stop reported while idle");

endmodule

bind ping_pong_capture_buffer_scheduler pcbs_checker u_pcbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// File: sim/pcbs_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the capture buffer scheduler: ring prediction and report compare.
module pcbs_result_checker
  import pcbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  cmd_i,
  input  logic      result_valid_o,
  input  out_word_t result_o,
  output int        mismatches,
  output int        outstanding,
  output int        words_taken,
  output int        reports_seen,
  output int        buffers_done,
  output int        stream_stops,
  output int        dma_errors,
  output int        arms_seen,
  output int        drops_full
);

  // Predicted ring state
  mode_e            mode_q;
  logic [IDX_W-1:0] fill_q;
  logic [IDX_W-1:0] drain_q;
  logic [PEND_W-1:0] waiting_q;
  desc_t            ring_desc  [RING_SLOTS];
  slot_state_e      ring_state [RING_SLOTS];

  out_word_t reports_due [$];
  out_word_t next_report;
  out_word_t oldest_report;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    words_taken  = 0;
    reports_seen = 0;
    buffers_done = 0;
    stream_stops = 0;
    dma_errors   = 0;
    arms_seen    = 0;
    drops_full   = 0;
  end

  function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W-1:0] i);
    return IDX_W'((int'(i) + 1) % RING_SLOTS);
  endfunction

  task automatic clear_ring();
    mode_q    = MODE_IDLE;
    fill_q    = '0;
    drain_q   = '0;
    waiting_q = '0;
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_desc[i]  = '0;
      ring_state[i] = SLOT_FREE;
    end
  endtask

  // Hand the oldest waiting descriptor to DMA, if there is one
  task automatic arm_head(inout out_word_t r);
    if (waiting_q != '0 && ring_state[drain_q] == SLOT_SCHEDULED) begin
      waiting_q           = waiting_q - PEND_W'(1);
      ring_state[drain_q] = SLOT_ARMED;
      mode_q              = MODE_STREAMING;
      r.arm_valid         = 1'b1;
      r.arm_address       = ring_desc[drain_q].addr;
      r.arm_count         = ring_desc[drain_q].count;
      r.arm_handler       = ring_desc[drain_q].handler;
    end
  endtask

  // Apply one command word to the predicted ring, giving its report
  task automatic advance_ring(input in_word_t w, output out_word_t r);
    r = '0;
    case (w.command)
      CMD_SCHEDULE: begin
        if (ring_state[fill_q] == SLOT_FREE) begin
          ring_desc[fill_q].addr    = w.buffer_address;
          ring_desc[fill_q].count   = w.sample_count;
          ring_desc[fill_q].handler = w.handler_id;
          ring_state[fill_q]        = SLOT_SCHEDULED;
          fill_q                    = ring_wrap(fill_q);
          waiting_q                 = waiting_q + PEND_W'(1);
          if (mode_q == MODE_IDLE || mode_q == MODE_STOPPED) begin
            arm_head(r);
          end
        end else begin
          drops_full++;
        end
      end
      CMD_COMPLETE: begin
        // a completion with nothing armed is spurious and changes nothing
        if (ring_state[drain_q] == SLOT_ARMED) begin
          r.rx_complete       = 1'b1;
          r.done_slot         = drain_q[0];
          r.done_address      = ring_desc[drain_q].addr;
          r.done_count        = ring_desc[drain_q].count;
          ring_state[drain_q] = SLOT_FREE;
          ring_desc[drain_q]  = '0;
          drain_q             = ring_wrap(drain_q);
          if (waiting_q != '0) begin
            arm_head(r);
          end else begin
            mode_q           = MODE_STOPPED;
            r.stream_stopped = 1'b1;
          end
        end
        r.overrun = w.overflow_seen;
      end
      CMD_ERROR: begin
        // an armed slot falls back to waiting and is re-armed first
        if (ring_state[drain_q] == SLOT_ARMED) begin
          ring_state[drain_q] = SLOT_SCHEDULED;
          waiting_q           = waiting_q + PEND_W'(1);
        end
        mode_q      = MODE_STOPPED;
        r.dma_error = 1'b1;
        r.overrun   = w.overflow_seen;
      end
      default: begin
        // abort is ignored while idle
        if (mode_q != MODE_IDLE) begin
          clear_ring();
        end
      end
    endcase
    r.active = (mode_q != MODE_IDLE);
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic compare_report(input out_word_t want, input out_word_t got);
    int bad;
    bad = 0;
    bad += field_differs("rx_complete", 32'(want.rx_complete), 32'(got.rx_complete));
    bad += field_differs("stream_stopped", 32'(want.stream_stopped),
                         32'(got.stream_stopped));
    bad += field_differs("dma_error", 32'(want.dma_error), 32'(got.dma_error));
    bad += field_differs("overrun", 32'(want.overrun), 32'(got.overrun));
    bad += field_differs("arm_valid", 32'(want.arm_valid), 32'(got.arm_valid));
    bad += field_differs("arm_address", want.arm_address, got.arm_address);
    bad += field_differs("arm_count", 32'(want.arm_count), 32'(got.arm_count));
    bad += field_differs("arm_handler", want.arm_handler, got.arm_handler);
    bad += field_differs("done_slot", 32'(want.done_slot), 32'(got.done_slot));
    bad += field_differs("done_address", want.done_address, got.done_address);
    bad += field_differs("done_count", 32'(want.done_count), 32'(got.done_count));
    bad += field_differs("active", 32'(want.active), 32'(got.active));
    mismatches += bad;
  endtask

  // Reports are matched first, then the word taken at this edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_ring();
      reports_due.delete();
      outstanding = 0;
    end else begin
      if (result_valid_o) begin
        reports_seen++;
        if (reports_due.size() == 0) begin
          $display("%0t ns: report with none pending, expected nothing, actual 0x%0h",
                   $time, result_o);
          mismatches++;
        end else begin
          oldest_report = reports_due.pop_front();
          compare_report(oldest_report, result_o);
        end
      end
      if (start && !busy) begin
        words_taken++;
        advance_ring(cmd_i, next_report);
        reports_due.push_back(next_report);
        buffers_done += int'(next_report.rx_complete);
        stream_stops += int'(next_report.stream_stopped);
        dma_errors   += int'(next_report.dma_error);
        arms_seen    += int'(next_report.arm_valid);
      end
      outstanding = reports_due.size();
    end
  end

endmodule

// File: sim/tb_ping_pong_capture_buffer_scheduler.sv
`timescale 1ns / 1ps
// Testbench top for the capture buffer scheduler: clock, reset, command stimulus, verdict.
module tb_ping_pong_capture_buffer_scheduler;
  import pcbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 213;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  cmd_i;
  logic      result_valid_o;
  out_word_t result_o;

  int mismatches, outstanding, words_taken, reports_seen;
  int buffers_done, stream_stops, dma_errors, arms_seen, drops_full;
  int idle_pct;
  int quiet_cycles;

  ping_pong_capture_buffer_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  pcbs_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_taken   (words_taken),
    .reports_seen  (reports_seen),
    .buffers_done  (buffers_done),
    .stream_stops  (stream_stops),
    .dma_errors    (dma_errors),
    .arms_seen     (arms_seen),
    .drops_full    (drops_full)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: too long with no word taken and no report out
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** ping_pong_capture_buffer_scheduler: FAILED **");
      $finish;
    end
  end

  function automatic in_word_t make_word(input cmd_e c, input logic [31:0] addr,
                                         input logic [15:0] cnt, input logic [31:0] hnd,
                                         input logic ovf);
    in_word_t w;
    w.command        = c;
    w.buffer_address = addr;
    w.sample_count   = cnt;
    w.handler_id     = hnd;
    w.overflow_seen  = ovf;
    return w;
  endfunction

  // Mostly schedule/complete traffic, some errors, rare aborts; payload random, at times all ones or all zeros
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned roll;
    roll            = $urandom_range(99);
    w.command       = (roll < 48) ? CMD_SCHEDULE :
                      (roll < 84) ? CMD_COMPLETE :
                      (roll < 95) ? CMD_ERROR : CMD_ABORT;
    w.buffer_address = $urandom();
    w.sample_count   = 16'($urandom_range(16'hFFFF));
    w.handler_id     = $urandom();
    w.overflow_seen  = 1'($urandom_range(1));
    if ($urandom_range(7) == 0) begin
      w.buffer_address = $urandom_range(1) ? '1 : '0;
      w.sample_count   = $urandom_range(1) ? '1 : '0;
      w.handler_id     = $urandom_range(1) ? '1 : '0;
    end
    return w;
  endfunction

  // Present one word after an optional random gap; hold until it is taken
  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off the sender until every report has come back
  task automatic drain_reports();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd_i    = '0;
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command, each corner of the ring
    send_word(make_word(CMD_ABORT, '1, '1, '1, 1'b1));        // abort while idle
    send_word(make_word(CMD_COMPLETE, '1, '1, '1, 1'b1));     // spurious completion
    send_word(make_word(CMD_SCHEDULE, '0, '0, '0, 1'b0));     // arms slot 0
    send_word(make_word(CMD_SCHEDULE, '1, '1, '1, 1'b1));     // waits in slot 1
    send_word(make_word(CMD_SCHEDULE, 32'h1234_5678, 16'h9ABC, 32'hDEAD_BEEF, 1'b0)); // full
    send_word(make_word(CMD_COMPLETE, '0, '0, '0, 1'b0));     // done 0, arm 1
    send_word(make_word(CMD_COMPLETE, '0, '0, '0, 1'b1));     // done 1, stream stops
    send_word(make_word(CMD_COMPLETE, '0, '0, '0, 1'b0));     // spurious while stopped
    send_word(make_word(CMD_SCHEDULE, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 1'b1));
    send_word(make_word(CMD_ERROR, '0, '0, '0, 1'b1));        // armed slot falls back
    send_word(make_word(CMD_SCHEDULE, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 1'b0));
    send_word(make_word(CMD_COMPLETE, '1, '1, '1, 1'b0));
    send_word(make_word(CMD_ERROR, '1, '1, '1, 1'b0));
    send_word(make_word(CMD_ABORT, '0, '0, '0, 1'b0));        // full reset
    send_word(make_word(CMD_ERROR, '0, '0, '0, 1'b0));        // error while idle
    send_word(make_word(CMD_ABORT, '1, '1, '1, 1'b1));
    send_word(make_word(CMD_SCHEDULE, '1, '0, '1, 1'b0));
    send_word(make_word(CMD_SCHEDULE, '0, '1, '0, 1'b1));
    send_word(make_word(CMD_COMPLETE, '0, '0, '0, 1'b1));
    send_word(make_word(CMD_COMPLETE, '0, '0, '0, 1'b0));
    send_word(make_word(CMD_ABORT, '0, '0, '0, 1'b0));
    drain_reports();

    // Random traffic in phases of sender idling, with a full drain between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 59;
        2:       idle_pct = 9;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
      drain_reports();
    end

    repeat (8) @(negedge clk_i);
    $display("Ran %0d command words with %0d reports checked against the ring prediction.",
             words_taken, reports_seen);
    $display("Covered %0d arms, %0d completions, %0d stream stops, %0d DMA errors, %0d drops.",
             arms_seen, buffers_done, stream_stops, dma_errors, drops_full);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** ping_pong_capture_buffer_scheduler: PASSED **");
    end else begin
      $display("** ping_pong_capture_buffer_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
